// File: sv/dfa_tok_pkg.sv
package dfa_tok_pkg;

    localparam int KIND_W = 5;
    localparam int ERR_W = 3;
    localparam int OUT_W = 16;
    localparam int RES_DEPTH = 4;
    localparam int RES_IDX_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_STAR    = 5'd0;
    localparam logic [KIND_W-1:0] KIND_PERIOD  = 5'd11;
    localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd15;
    localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd16;
    localparam logic [KIND_W-1:0] KIND_QUOTED  = 5'd17;
    localparam logic [KIND_W-1:0] KIND_LITERAL = 5'd18;
    localparam logic [KIND_W-1:0] KIND_END     = 5'd19;

    localparam logic [ERR_W-1:0] ERR_NONE           = 3'd0;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN_TOKEN  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_UNEXPECTED_END = 3'd2;
    localparam logic [ERR_W-1:0] ERR_EMPTY_QUOTED   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BAD_ESCAPE     = 3'd4;

    typedef enum logic [4:0] {
        ST_START   = 5'd0,
        ST_STAR    = 5'd1,
        ST_COMMA   = 5'd2,
        ST_SLASH   = 5'd3,
        ST_EQ      = 5'd4,
        ST_GT      = 5'd5,
        ST_GE      = 5'd6,
        ST_LT      = 5'd7,
        ST_LE      = 5'd8,
        ST_NE      = 5'd9,
        ST_LPAREN  = 5'd10,
        ST_RPAREN  = 5'd11,
        ST_DOT     = 5'd12,
        ST_PLUS    = 5'd13,
        ST_SEMI    = 5'd14,
        ST_MINUS   = 5'd15,
        ST_INT     = 5'd16,
        ST_INT_DOT = 5'd17,
        ST_FRAC    = 5'd18,
        ST_WORD    = 5'd19,
        ST_QID     = 5'd20,
        ST_QID_END = 5'd21,
        ST_LIT     = 5'd22,
        ST_LIT_ESC = 5'd23,
        ST_LIT_END = 5'd24
    } scan_state_t;

    typedef struct packed {
        logic        ok;
        scan_state_t nxt;
    } move_t;

    typedef struct packed {
        logic [KIND_W-1:0] token_kind;
        logic [ERR_W-1:0]  error_code;
        logic [OUT_W-1:0]  start_offset;
        logic [OUT_W-1:0]  token_length;
        logic              last_of_run;
    } result_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0]          count;
        result_t [RES_DEPTH-1:0]       item;
    } batch_t;

endpackage

// File: sv/dfa_token_scanner.sv
// Streaming longest-match tokenizer. Source bytes enter one per transaction on the s_ channel
// (tuser bit 0 marks a real byte, tlast ends the source) and the block emits one transaction
// per token on the m_ channel: start offset and length in tdata, kind and error code in
// tuser, tlast on the final token caused by an input transaction. Whitespace is skipped, a
// number followed by a period and a non-digit is split into the number and a period token,
// and end of source flushes the pending token and emits an end token, after which offsets
// restart at zero. A byte is accepted every cycle while the result buffer takes its tokens:
// the scanner state advances through one table step between the input register and the
// four-entry result buffer, so the sustained rate is one input transaction per cycle while
// each yields at most one token and the output is not stalled; a transaction that yields k
// tokens loads all k into that buffer, and the input waits only for it to drain. A token
// passes the input register, then the result buffer. There is no clearing pass after reset.
module dfa_token_scanner
    import dfa_tok_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value
    input  logic [0:0]  s_tuser,   // byte_valid
    input  logic        s_tlast,   // end_of_source
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // start_offset, token_length
    output logic [7:0]  m_tuser,   // token_kind, error_code
    output logic        m_tlast    // last_of_run
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_bv_reg;
    logic       in_eos_reg;

    batch_t batch;
    logic   obuf_free;
    logic   take;

    assign take = in_valid_reg && ((batch.count == '0) || obuf_free);
    assign s_tready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_bv_reg <= s_tuser[0];
            in_eos_reg <= s_tlast;
        end
    end

    dfa_tok_core #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take         (take),
        .byte_value   (in_byte_reg),
        .byte_valid   (in_bv_reg),
        .end_of_source(in_eos_reg),
        .batch        (batch)
    );

    dfa_tok_obuf u_obuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (take && (batch.count != '0)),
        .batch   (batch),
        .free    (obuf_free),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

// File: sv/dfa_tok_core.sv
module dfa_tok_core
    import dfa_tok_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       take,
    input  logic [7:0] byte_value,
    input  logic       byte_valid,
    input  logic       end_of_source,
    output batch_t     batch
);

    localparam int EXT_W = (OFFSET_BITS > OUT_W) ? OFFSET_BITS : OUT_W;

    typedef logic [OFFSET_BITS-1:0] pos_t;

    scan_state_t state_reg, state_next;
    scan_state_t accept_reg, accept_next;
    pos_t        start_reg, start_next;
    pos_t        end_reg, end_next;
    pos_t        pos_reg, pos_next;
    logic        esc_reg, esc_next;
    logic        quoted_reg, quoted_next;

    scan_state_t mid_state, mid_accept;
    pos_t        mid_start, mid_end, mid_pos;
    logic        mid_esc, mid_quoted;

    move_t byte_mv, start_mv;
    logic  stuck;

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_";
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == " " || c == 8'h0A || c == 8'h09 || c == 8'h0D;
    endfunction

    function automatic logic escape_ok(logic [7:0] c);
        return c == "n" || c == "r" || c == "t" || c == "'" || c == "\\";
    endfunction

    function automatic logic accepting(scan_state_t s);
        return (s >= ST_STAR && s <= ST_INT) || s == ST_FRAC || s == ST_WORD
            || s == ST_QID_END || s == ST_LIT_END;
    endfunction

    function automatic move_t dfa_move(scan_state_t s, logic [7:0] c);
        move_t m;
        m.ok = 1'b1;
        m.nxt = ST_START;
        unique case (s)
            ST_START: begin
                priority if (c == "*") m.nxt = ST_STAR;
                else if (c == ",") m.nxt = ST_COMMA;
                else if (c == "/") m.nxt = ST_SLASH;
                else if (c == "=") m.nxt = ST_EQ;
                else if (c == ">") m.nxt = ST_GT;
                else if (c == "<") m.nxt = ST_LT;
                else if (c == "(") m.nxt = ST_LPAREN;
                else if (c == ")") m.nxt = ST_RPAREN;
                else if (c == ".") m.nxt = ST_DOT;
                else if (c == "+") m.nxt = ST_PLUS;
                else if (c == ";") m.nxt = ST_SEMI;
                else if (c == "-") m.nxt = ST_MINUS;
                else if (c == "\"") m.nxt = ST_QID;
                else if (c == "'") m.nxt = ST_LIT;
                else if (is_digit(c)) m.nxt = ST_INT;
                else if (is_word(c)) m.nxt = ST_WORD;
                else m.ok = 1'b0;
            end
            ST_GT: begin
                if (c == "=") m.nxt = ST_GE;
                else m.ok = 1'b0;
            end
            ST_LT: begin
                priority if (c == "=") m.nxt = ST_LE;
                else if (c == ">") m.nxt = ST_NE;
                else m.ok = 1'b0;
            end
            ST_INT: begin
                priority if (is_digit(c)) m.nxt = ST_INT;
                else if (c == ".") m.nxt = ST_INT_DOT;
                else m.ok = 1'b0;
            end
            ST_INT_DOT, ST_FRAC: begin
                if (is_digit(c)) m.nxt = ST_FRAC;
                else m.ok = 1'b0;
            end
            ST_WORD: begin
                if (is_word(c)) m.nxt = ST_WORD;
                else m.ok = 1'b0;
            end
            ST_QID: begin
                priority if (is_word(c)) m.nxt = ST_QID;
                else if (c == "\"") m.nxt = ST_QID_END;
                else m.ok = 1'b0;
            end
            ST_LIT: begin
                priority if (c == "'") m.nxt = ST_LIT_END;
                else if (c == "\\") m.nxt = ST_LIT_ESC;
                else m.nxt = ST_LIT;
            end
            ST_LIT_ESC: m.nxt = ST_LIT;
            default: m.ok = 1'b0;
        endcase
        return m;
    endfunction

    function automatic pos_t sat_inc(pos_t v);
        return (v == {OFFSET_BITS{1'b1}}) ? v : v + OFFSET_BITS'(1);
    endfunction

    function automatic logic [OUT_W-1:0] clamp(pos_t v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        return (e > EXT_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : e[OUT_W-1:0];
    endfunction

    function automatic pos_t span(pos_t from, pos_t upto);
        return (upto >= from) ? upto - from : '0;
    endfunction

    function automatic result_t finish_res(scan_state_t st, scan_state_t acc, pos_t ts,
                                           pos_t ae, logic eb, logic qc, pos_t stop);
        result_t r;
        r.last_of_run = 1'b0;
        r.start_offset = clamp(ts);
        r.error_code = ERR_NONE;
        r.token_length = clamp(span(ts, ae));
        if (acc == ST_START) begin
            r.token_kind = (st == ST_QID) ? KIND_QUOTED : KIND_LITERAL;
            r.error_code = ERR_UNEXPECTED_END;
            r.token_length = clamp(span(ts, stop));
        end else if (st == ST_INT_DOT) begin
            r.token_kind = KIND_NUMBER;
        end else if (acc <= ST_MINUS) begin
            r.token_kind = KIND_W'(acc) - KIND_W'(1);
        end else if (acc == ST_INT || acc == ST_FRAC) begin
            r.token_kind = KIND_NUMBER;
        end else if (acc == ST_WORD) begin
            r.token_kind = KIND_IDENT;
        end else if (acc == ST_QID_END) begin
            r.token_kind = KIND_QUOTED;
            r.error_code = qc ? ERR_NONE : ERR_EMPTY_QUOTED;
        end else begin
            r.token_kind = KIND_LITERAL;
            r.error_code = eb ? ERR_BAD_ESCAPE : ERR_NONE;
        end
        return r;
    endfunction

    // period backed off from a number, rescanned as its own token
    function automatic result_t period_res(pos_t ae);
        result_t r;
        r.token_kind = KIND_PERIOD;
        r.error_code = ERR_NONE;
        r.start_offset = clamp(ae);
        r.token_length = clamp(sat_inc(ae) - ae);
        r.last_of_run = 1'b0;
        return r;
    endfunction

    function automatic result_t simple_res(logic [KIND_W-1:0] kind, logic [ERR_W-1:0] err,
                                           pos_t at, logic [OUT_W-1:0] len);
        result_t r;
        r.token_kind = kind;
        r.error_code = err;
        r.start_offset = clamp(at);
        r.token_length = len;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    assign byte_mv = dfa_move(state_reg, byte_value);
    assign start_mv = dfa_move(ST_START, byte_value);
    assign stuck = (state_reg != ST_START) && !byte_mv.ok;
    assign mid_pos = byte_valid ? sat_inc(pos_reg) : pos_reg;

    // state after the byte of this transaction
    always_comb begin
        mid_state = state_reg;
        mid_accept = accept_reg;
        mid_start = start_reg;
        mid_end = end_reg;
        mid_esc = esc_reg;
        mid_quoted = quoted_reg;
        if (byte_valid) begin
            if (!stuck && state_reg != ST_START) begin
                if (state_reg == ST_LIT_ESC && !escape_ok(byte_value)) begin
                    mid_esc = 1'b1;
                end
                if (state_reg == ST_QID && byte_mv.nxt == ST_QID) begin
                    mid_quoted = 1'b1;
                end
                mid_state = byte_mv.nxt;
                if (accepting(byte_mv.nxt)) begin
                    mid_accept = byte_mv.nxt;
                    mid_end = sat_inc(pos_reg);
                end
            end else begin
                if (stuck) begin
                    if (state_reg == ST_INT_DOT) begin
                        mid_start = end_reg;
                        mid_end = sat_inc(end_reg);
                    end
                    mid_state = ST_START;
                    mid_accept = ST_START;
                    mid_esc = 1'b0;
                    mid_quoted = 1'b0;
                end
                if (!is_space(byte_value) && start_mv.ok) begin
                    mid_state = start_mv.nxt;
                    mid_accept = ST_START;
                    mid_esc = 1'b0;
                    mid_quoted = 1'b0;
                    mid_start = pos_reg;
                    if (accepting(start_mv.nxt)) begin
                        mid_accept = start_mv.nxt;
                        mid_end = sat_inc(pos_reg);
                    end
                end
            end
        end
    end

    always_comb begin
        if (end_of_source) begin
            state_next = ST_START;
            accept_next = ST_START;
            start_next = '0;
            end_next = '0;
            pos_next = '0;
            esc_next = 1'b0;
            quoted_next = 1'b0;
        end else begin
            state_next = mid_state;
            accept_next = mid_accept;
            start_next = mid_start;
            end_next = mid_end;
            pos_next = mid_pos;
            esc_next = mid_esc;
            quoted_next = mid_quoted;
        end
    end

    always_comb begin : emit_blk
        logic [RES_CNT_W-1:0] n;
        n = '0;
        batch.item = '0;
        if (byte_valid) begin
            if (stuck) begin
                batch.item[n[RES_IDX_W-1:0]] = finish_res(state_reg, accept_reg, start_reg,
                                                          end_reg, esc_reg, quoted_reg,
                                                          pos_reg);
                n = n + RES_CNT_W'(1);
                if (state_reg == ST_INT_DOT) begin
                    batch.item[n[RES_IDX_W-1:0]] = period_res(end_reg);
                    n = n + RES_CNT_W'(1);
                end
            end
            if ((stuck || state_reg == ST_START) && !is_space(byte_value) && !start_mv.ok) begin
                batch.item[n[RES_IDX_W-1:0]] = simple_res(KIND_STAR, ERR_UNKNOWN_TOKEN,
                                                          pos_reg, OUT_W'(1));
                n = n + RES_CNT_W'(1);
            end
        end
        if (end_of_source) begin
            if (mid_state != ST_START) begin
                batch.item[n[RES_IDX_W-1:0]] = finish_res(mid_state, mid_accept, mid_start,
                                                          mid_end, mid_esc, mid_quoted,
                                                          mid_pos);
                n = n + RES_CNT_W'(1);
                if (mid_state == ST_INT_DOT) begin
                    batch.item[n[RES_IDX_W-1:0]] = period_res(mid_end);
                    n = n + RES_CNT_W'(1);
                end
            end
            batch.item[n[RES_IDX_W-1:0]] = simple_res(KIND_END, ERR_NONE, mid_pos, '0);
            n = n + RES_CNT_W'(1);
        end
        if (n != '0) begin
            batch.item[RES_IDX_W'(n - RES_CNT_W'(1))].last_of_run = 1'b1;
        end
        batch.count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_START;
            accept_reg <= ST_START;
            start_reg <= '0;
            end_reg <= '0;
            pos_reg <= '0;
            esc_reg <= 1'b0;
            quoted_reg <= 1'b0;
        end else if (take) begin
            state_reg <= state_next;
            accept_reg <= accept_next;
            start_reg <= start_next;
            end_reg <= end_next;
            pos_reg <= pos_next;
            esc_reg <= esc_next;
            quoted_reg <= quoted_next;
        end
    end

endmodule

// File: sv/dfa_tok_obuf.sv
module dfa_tok_obuf
    import dfa_tok_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  batch_t      batch,
    output logic        free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // start_offset, token_length
    output logic [7:0]  m_tuser,   // token_kind, error_code
    output logic        m_tlast
);

    result_t [RES_DEPTH-1:0] item_reg, item_next;
    logic [RES_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                    pop;

    assign m_tvalid = cnt_reg != '0;
    assign pop = m_tvalid && m_tready;
    assign free = (cnt_reg == '0) || (cnt_reg == RES_CNT_W'(1) && m_tready);

    assign m_tdata = {item_reg[0].token_length, item_reg[0].start_offset};
    assign m_tuser = {item_reg[0].error_code, item_reg[0].token_kind};
    assign m_tlast = item_reg[0].last_of_run;

    always_comb begin
        item_next = item_reg;
        cnt_next = cnt_reg;
        if (load) begin
            item_next = batch.item;
            cnt_next = batch.count;
        end else if (pop) begin
            for (int i = 0; i < RES_DEPTH - 1; i++) begin
                item_next[i] = item_reg[i + 1];
            end
            cnt_next = cnt_reg - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule
